/* rtl/twodo_pkg.sv */
package twodo_pkg;

   // Angles are Q3.28 radians inside 34-bit working words; CORDIC words are Q2.30.
   typedef logic signed [33:0] wide_type;
   typedef logic signed [31:0] word_type;

   localparam int DefaultCordicSteps = 24;

   localparam wide_type PiQ28     = 34'sd843314857;
   localparam wide_type HalfPiQ28 = 34'sd421657428;
   localparam wide_type TwoPiQ28  = 34'sd1686629713;
   localparam wide_type OneQ28    = 34'sd268435456;
   localparam wide_type GainQ30   = 34'sd652032874;
   localparam wide_type SmallQ28  = 34'sd4194304;

   // ceil(2^24 / 24); a product with it shifted down by 24 gives an exact
   // quotient by 24 for any value below 2^21.
   localparam wide_type Recip24Q24 = 34'sd699051;

   localparam logic [15:0] ResetWheelOffset    = 16'd1856;
   localparam logic [23:0] ResetInchesPerCount = 24'd336461;

   // Register indexes of the control port.
   localparam logic [1:0] RegLeftOffset  = 2'd0;
   localparam logic [1:0] RegRightOffset = 2'd1;
   localparam logic [1:0] RegBackOffset  = 2'd2;
   localparam logic [1:0] RegInchesPer   = 2'd3;

   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // Brings an angle of up to five pi in magnitude into [-pi, pi].
   function automatic wide_type wrap_angle(input wide_type a);
      wide_type v;
      v = a;
      if (v > PiQ28) v = v - TwoPiQ28;
      if (v > PiQ28) v = v - TwoPiQ28;
      if (v < -PiQ28) v = v + TwoPiQ28;
      if (v < -PiQ28) v = v + TwoPiQ28;
      return v;
   endfunction

   function automatic word_type sat32(input logic signed [71:0] v);
      word_type r;
      if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -72'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

/* rtl/three_wheel_odometry.sv */
// Channel  Direction  Payload (lowest bits first)                 Handshake
// req      in         left_count, right_count, back_count (32b)   req_tvalid/req_tready
// rsp      out        x_position, y_position, heading (32b)       rsp_tvalid/rsp_tready
// csr      in         register index 0..3, write data 24b         csr_we
//
// From the edge that accepts a request to the edge that loads its result the block runs, in
// order: the wheel distances, the heading-change division, the half-angle sine, the
// chord-factor division, the local offset, the rotation, and the global update and output.
// A small heading change replaces the chord-factor division by one reciprocal multiply;
// no heading change skips the half-angle sine, the chord factor and the local offset.
// The block is ready again in the cycle after the result is loaded.
// Reset is synchronous and active high; it clears pose and previous counts and sets the
// configuration registers to their reset values.
// A result waits in the output register; a stalled result channel holds the block only
// when the next result is ready to be written.
module three_wheel_odometry #(
   parameter int CORDIC_STEPS = twodo_pkg::DefaultCordicSteps
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // left_count, right_count, back_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // x_position, y_position, heading
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // Sequencer states.
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DL    = 5'd1;
   localparam logic [4:0] S_DR    = 5'd2;
   localparam logic [4:0] S_DS    = 5'd3;
   localparam logic [4:0] S_DSV   = 5'd4;
   localparam logic [4:0] S_TDIV  = 5'd5;
   localparam logic [4:0] S_TEND  = 5'd6;
   localparam logic [4:0] S_CHK   = 5'd7;
   localparam logic [4:0] S_COR1  = 5'd8;
   localparam logic [4:0] S_KSEL  = 5'd9;
   localparam logic [4:0] S_SERSQ = 5'd10;
   localparam logic [4:0] S_KDIV  = 5'd11;
   localparam logic [4:0] S_KEND  = 5'd12;
   localparam logic [4:0] S_LX1   = 5'd13;
   localparam logic [4:0] S_LX2   = 5'd14;
   localparam logic [4:0] S_LY1   = 5'd15;
   localparam logic [4:0] S_LY2   = 5'd16;
   localparam logic [4:0] S_LYE   = 5'd17;
   localparam logic [4:0] S_COR2  = 5'd18;
   localparam logic [4:0] S_GX1   = 5'd19;
   localparam logic [4:0] S_GX2   = 5'd20;
   localparam logic [4:0] S_GY1   = 5'd21;
   localparam logic [4:0] S_GY2   = 5'd22;
   localparam logic [4:0] S_UPD   = 5'd23;
   localparam logic [4:0] S_OUT   = 5'd24;

   logic [4:0] state_ff, state_in;

   // Configuration registers.
   logic [15:0] left_off_ff, right_off_ff, back_off_ff;
   logic [23:0] ipc_ff;

   // Pose and previous encoder counts.
   logic signed [31:0] last_l_ff, last_r_ff, last_b_ff;
   logic signed [31:0] heading_ff, x_ff, y_ff;
   logic signed [31:0] cnt_l_ff, cnt_r_ff, cnt_b_ff;

   // Per-request working values.
   logic signed [31:0] dl_ff, dr_ff, ds_ff, dth_ff;
   logic signed [33:0] s2_ff, k_ff, lx_ff, ly_ff;
   logic               small_ff;
   logic signed [67:0] prod_ff, acc_ff;
   logic signed [40:0] gx_ff;

   // Shared multiplier operands.
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_sh8, prod_sh28;

   // Shared restoring divider.
   logic [63:0] div_quo_ff;
   logic [31:0] div_rem_ff, div_den_ff;
   logic        div_neg_ff;
   logic [5:0]  div_cnt_ff;
   logic        div_load;
   logic [63:0] div_num;
   logic [31:0] div_dsr;
   logic        div_neg;
   logic [32:0] div_trial;
   logic signed [64:0] div_q;

   // Shared CORDIC.
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic [4:0]         ci_ff;
   logic               flip_ff;
   logic               cor_load;
   logic signed [33:0] cor_ang, cor_red, cor_xs, cor_ys, cor_at;
   logic               cor_flip;
   logic signed [33:0] cos_v, sin_v, s2_now;
   logic               cor_last;

   // Miscellaneous datapath values.
   logic signed [32:0] dd_diff;
   logic [32:0]        dd_mag;
   logic [33:0]        s2_mag;
   logic [31:0]        dth_mag;
   logic signed [33:0] dth_half, cor2_ang;
   logic signed [68:0] gsum;
   logic signed [40:0] gy_v;
   logic signed [71:0] x_sum, y_sum;
   logic signed [33:0] head_sum;

   logic signed [95:0] rsp_tdata_ff;
   logic               rsp_tvalid_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign prod_sh8  = prod_ff >>> 8;
   assign prod_sh28 = prod_ff >>> 28;

   assign div_trial = {div_rem_ff, div_quo_ff[63]};
   assign div_q     = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});

   // Sine and cosine as the CORDIC registers hold them, with the half-turn folded back.
   assign cos_v  = flip_ff ? -(cx_ff >>> 2) : (cx_ff >>> 2);
   assign sin_v  = flip_ff ? -(cy_ff >>> 2) : (cy_ff >>> 2);
   assign s2_now = sin_v <<< 1;
   assign cor_last = (ci_ff == 5'(CORDIC_STEPS - 1));

   assign dd_diff  = $signed({dl_ff[31], dl_ff}) - $signed({dr_ff[31], dr_ff});
   assign dd_mag   = dd_diff[32] ? 33'(-dd_diff) : 33'(dd_diff);
   assign s2_mag   = s2_now[33] ? 34'(-s2_now) : 34'(s2_now);
   assign dth_mag  = dth_ff[31] ? 32'(-dth_ff) : 32'(dth_ff);
   assign dth_half = $signed({{2{dth_ff[31]}}, dth_ff}) >>> 1;
   assign cor2_ang = twodo_pkg::wrap_angle($signed({{2{heading_ff[31]}}, heading_ff}) + dth_half);

   assign gsum     = $signed({acc_ff[67], acc_ff}) - $signed({prod_ff[67], prod_ff});
   assign gy_v     = 41'(gsum >>> 28);
   assign x_sum    = $signed({{40{x_ff[31]}}, x_ff}) + $signed({{31{gx_ff[40]}}, gx_ff});
   assign y_sum    = $signed({{40{y_ff[31]}}, y_ff}) + $signed({{31{gy_v[40]}}, gy_v});
   assign head_sum = $signed({{2{heading_ff[31]}}, heading_ff})
                   + $signed({{2{dth_ff[31]}}, dth_ff});

   // Angle reduction ahead of the CORDIC: into [-pi/2, pi/2], remembering a half turn.
   always_comb begin
      cor_red  = twodo_pkg::wrap_angle(cor_ang);
      cor_flip = 1'b0;
      if (cor_red > twodo_pkg::HalfPiQ28) begin
         cor_red  = cor_red - twodo_pkg::PiQ28;
         cor_flip = 1'b1;
      end else if (cor_red < -twodo_pkg::HalfPiQ28) begin
         cor_red  = cor_red + twodo_pkg::PiQ28;
         cor_flip = 1'b1;
      end
   end

   assign cor_xs = cx_ff >>> ci_ff;
   assign cor_ys = cy_ff >>> ci_ff;
   assign cor_at = $signed({2'b00, twodo_pkg::atan_q30(ci_ff)});

   // Operand selection for the shared units and the next state.
   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      div_load = 1'b0;
      div_num  = '0;
      div_dsr  = '0;
      div_neg  = 1'b0;
      cor_load = 1'b0;
      cor_ang  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DL;
         end
         S_DL: begin
            mul_a    = 34'(signed'(cnt_l_ff - last_l_ff));
            mul_b    = $signed({10'b0, ipc_ff});
            state_in = S_DR;
         end
         S_DR: begin
            mul_a    = 34'(signed'(cnt_r_ff - last_r_ff));
            mul_b    = $signed({10'b0, ipc_ff});
            state_in = S_DS;
         end
         S_DS: begin
            mul_a    = 34'(signed'(cnt_b_ff - last_b_ff));
            mul_b    = $signed({10'b0, ipc_ff});
            state_in = S_DSV;
         end
         S_DSV: begin
            div_load = 1'b1;
            div_num  = {11'b0, dd_mag, 20'b0};
            div_dsr  = {15'b0, 17'({1'b0, left_off_ff} + {1'b0, right_off_ff})};
            div_neg  = dd_diff[32];
            state_in = S_TDIV;
         end
         S_TDIV: begin
            if (div_cnt_ff == 6'd63) state_in = S_TEND;
         end
         S_TEND: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            cor_load = 1'b1;
            if (dth_ff == '0) begin
               cor_ang  = cor2_ang;
               state_in = S_COR2;
            end else begin
               cor_ang  = dth_half;
               state_in = S_COR1;
            end
         end
         S_COR1: begin
            if (cor_last) state_in = S_KSEL;
         end
         S_KSEL: begin
            mul_a = $signed({{2{dth_ff[31]}}, dth_ff});
            mul_b = $signed({{2{dth_ff[31]}}, dth_ff});
            if ($signed({2'b00, dth_mag}) >= twodo_pkg::SmallQ28) begin
               div_load = 1'b1;
               div_num  = {2'b00, s2_mag, 28'b0};
               div_dsr  = dth_mag;
               div_neg  = s2_now[33] ^ dth_ff[31];
               state_in = S_KDIV;
            end else begin
               state_in = S_SERSQ;
            end
         end
         S_SERSQ: begin
            // dth^2 >> 28 stays below 2^16 here; divide it by 24 with a reciprocal.
            mul_a    = prod_sh28[33:0];
            mul_b    = twodo_pkg::Recip24Q24;
            state_in = S_KEND;
         end
         S_KDIV: begin
            if (div_cnt_ff == 6'd63) state_in = S_KEND;
         end
         S_KEND: begin
            state_in = S_LX1;
         end
         S_LX1: begin
            mul_a    = $signed({{2{ds_ff[31]}}, ds_ff});
            mul_b    = k_ff;
            state_in = S_LX2;
         end
         S_LX2: begin
            mul_a    = $signed({10'b0, back_off_ff, 8'b0});
            mul_b    = s2_ff;
            state_in = S_LY1;
         end
         S_LY1: begin
            mul_a    = $signed({{2{dr_ff[31]}}, dr_ff});
            mul_b    = k_ff;
            state_in = S_LY2;
         end
         S_LY2: begin
            mul_a    = $signed({10'b0, right_off_ff, 8'b0});
            mul_b    = s2_ff;
            state_in = S_LYE;
         end
         S_LYE: begin
            cor_load = 1'b1;
            cor_ang  = cor2_ang;
            state_in = S_COR2;
         end
         S_COR2: begin
            if (cor_last) state_in = S_GX1;
         end
         S_GX1: begin
            mul_a    = lx_ff;
            mul_b    = cos_v;
            state_in = S_GX2;
         end
         S_GX2: begin
            mul_a    = ly_ff;
            mul_b    = sin_v;
            state_in = S_GY1;
         end
         S_GY1: begin
            mul_a    = ly_ff;
            mul_b    = cos_v;
            state_in = S_GY2;
         end
         S_GY2: begin
            mul_a    = lx_ff;
            mul_b    = sin_v;
            state_in = S_UPD;
         end
         S_UPD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state and pose.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         left_off_ff   <= twodo_pkg::ResetWheelOffset;
         right_off_ff  <= twodo_pkg::ResetWheelOffset;
         back_off_ff   <= twodo_pkg::ResetWheelOffset;
         ipc_ff        <= twodo_pkg::ResetInchesPerCount;
         last_l_ff     <= '0;
         last_r_ff     <= '0;
         last_b_ff     <= '0;
         heading_ff    <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               twodo_pkg::RegLeftOffset:  left_off_ff  <= csr_wdata[15:0];
               twodo_pkg::RegRightOffset: right_off_ff <= csr_wdata[15:0];
               twodo_pkg::RegBackOffset:  back_off_ff  <= csr_wdata[15:0];
               twodo_pkg::RegInchesPer:   ipc_ff       <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_UPD) begin
            x_ff       <= twodo_pkg::sat32(x_sum);
            y_ff       <= twodo_pkg::sat32(y_sum);
            heading_ff <= 32'(twodo_pkg::wrap_angle(head_sum));
            last_l_ff  <= cnt_l_ff;
            last_r_ff  <= cnt_r_ff;
            last_b_ff  <= cnt_b_ff;
         end
         if (state_ff == S_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == S_IDLE && req_tvalid) begin
         cnt_l_ff <= req_tdata[31:0];
         cnt_r_ff <= req_tdata[63:32];
         cnt_b_ff <= req_tdata[95:64];
      end
      if (state_ff == S_DR) dl_ff <= twodo_pkg::sat32($signed({{4{prod_sh8[67]}}, prod_sh8}));
      if (state_ff == S_DS) dr_ff <= twodo_pkg::sat32($signed({{4{prod_sh8[67]}}, prod_sh8}));
      if (state_ff == S_DSV) ds_ff <= twodo_pkg::sat32($signed({{4{prod_sh8[67]}}, prod_sh8}));
      if (state_ff == S_TEND) begin
         // A zero offset sum leaves the heading unchanged.
         if (left_off_ff == '0 && right_off_ff == '0) dth_ff <= '0;
         else dth_ff <= twodo_pkg::sat32($signed({{7{div_q[64]}}, div_q}));
      end
      if (state_ff == S_CHK && dth_ff == '0) begin
         lx_ff <= $signed({{2{ds_ff[31]}}, ds_ff});
         ly_ff <= $signed({{2{dr_ff[31]}}, dr_ff});
      end
      if (state_ff == S_KSEL) begin
         s2_ff    <= s2_now;
         small_ff <= ($signed({2'b00, dth_mag}) < twodo_pkg::SmallQ28);
      end
      if (state_ff == S_KEND) begin
         // Small angles use the series 1 - dth^2/24 for sin(x)/x.
         k_ff <= small_ff ? twodo_pkg::OneQ28 - $signed(prod_ff[57:24]) : div_q[33:0];
      end
      if (state_ff == S_LX2) lx_ff <= prod_sh28[33:0];
      if (state_ff == S_LY1) lx_ff <= lx_ff + prod_sh28[33:0];
      if (state_ff == S_LY2) ly_ff <= prod_sh28[33:0];
      if (state_ff == S_LYE) ly_ff <= ly_ff + prod_sh28[33:0];
      if (state_ff == S_GX2 || state_ff == S_GY2) acc_ff <= prod_ff;
      if (state_ff == S_GY1) begin
         gx_ff <= 41'(($signed({acc_ff[67], acc_ff}) + $signed({prod_ff[67], prod_ff})) >>> 28);
      end
      if (state_ff == S_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tdata_ff <= {heading_ff, y_ff, x_ff};
      end

      // Divider: one quotient bit per cycle, sign applied at the end.
      if (div_load) begin
         div_quo_ff <= div_num;
         div_rem_ff <= '0;
         div_den_ff <= div_dsr;
         div_neg_ff <= div_neg;
         div_cnt_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_ff + 6'd1;
         if (div_trial >= {1'b0, div_den_ff}) begin
            div_rem_ff <= 32'(div_trial - {1'b0, div_den_ff});
            div_quo_ff <= {div_quo_ff[62:0], 1'b1};
         end else begin
            div_rem_ff <= div_trial[31:0];
            div_quo_ff <= {div_quo_ff[62:0], 1'b0};
         end
      end

      // CORDIC in rotation mode, one micro-rotation per cycle.
      if (cor_load) begin
         cx_ff   <= twodo_pkg::GainQ30;
         cy_ff   <= '0;
         cz_ff   <= cor_red <<< 2;
         ci_ff   <= '0;
         flip_ff <= cor_flip;
      end else if (state_ff == S_COR1 || state_ff == S_COR2) begin
         ci_ff <= ci_ff + 5'd1;
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - cor_ys;
            cy_ff <= cy_ff + cor_xs;
            cz_ff <= cz_ff - cor_at;
         end else begin
            cx_ff <= cx_ff + cor_ys;
            cy_ff <= cy_ff - cor_xs;
            cz_ff <= cz_ff + cor_at;
         end
      end
   end

endmodule

/* rtl/twodo_checker.sv */
module twodo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // A held result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // No result appears right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A reported heading always lies within plus or minus pi.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[95:64]) <= 32'(twodo_pkg::PiQ28)) &&
                     ($signed(rsp_tdata[95:64]) >= -32'(twodo_pkg::PiQ28)))
      else $error("heading out of range");

endmodule

bind three_wheel_odometry twodo_checker u_twodo_checker (.*);
